### hw/rtl/hccp_pkg.sv
// Shared types and constants of the Hermite cubic curve point generator.
`timescale 1ns / 1ps
`default_nettype none

package hccp_pkg;

    localparam int QUALITY_W   = 7;
    localparam int T_STEP_W    = 17;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [QUALITY_W-1:0] QUALITY_RESET = 7'd16;
    localparam logic [T_STEP_W-1:0]  T_STEP_RESET  = 17'd4096;

    // Register index, taken from paddr[2].
    localparam logic REG_QUALITY = 1'b0;
    localparam logic REG_T_STEP  = 1'b1;

    typedef struct packed {
        logic [QUALITY_W-1:0] quality;
        logic [T_STEP_W-1:0]  t_step;
    } t_cfg;

endpackage

`default_nettype wire

### hw/rtl/hccp_if.sv
// Valid/ready channel interfaces for control points in and curve points out.
`timescale 1ns / 1ps
`default_nettype none

interface hccp_in_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] handle_x;
    logic signed [COORD_WIDTH-1:0] handle_y;
    logic                          start_curve;

    modport source (output valid, point_x, point_y, handle_x, handle_y, start_curve,
                    input ready);
    modport sink   (input valid, point_x, point_y, handle_x, handle_y, start_curve,
                    output ready);
endinterface

interface hccp_out_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] curve_x;
    logic signed [COORD_WIDTH-1:0] curve_y;
    logic                          last_point;

    modport source (output valid, curve_x, curve_y, last_point, input ready);
    modport sink   (input valid, curve_x, curve_y, last_point, output ready);
endinterface

`default_nettype wire

### hw/rtl/hccp_cfg.sv
// APB register file holding quality and t_step.
`timescale 1ns / 1ps
`default_nettype none

module hccp_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [hccp_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [hccp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [hccp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output hccp_pkg::t_cfg                        o_cfg
);

    logic [hccp_pkg::QUALITY_W-1:0] r_quality;
    logic [hccp_pkg::T_STEP_W-1:0]  r_t_step;
    logic                           wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quality <= hccp_pkg::QUALITY_RESET;
            r_t_step  <= hccp_pkg::T_STEP_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                hccp_pkg::REG_QUALITY: begin
                    r_quality <= pwdata[hccp_pkg::QUALITY_W-1:0];
                end
                hccp_pkg::REG_T_STEP: begin
                    r_t_step <= pwdata[hccp_pkg::T_STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            hccp_pkg::REG_QUALITY: begin
                prdata = {{(hccp_pkg::APB_DATA_W-hccp_pkg::QUALITY_W){1'b0}}, r_quality};
            end
            hccp_pkg::REG_T_STEP: begin
                prdata = {{(hccp_pkg::APB_DATA_W-hccp_pkg::T_STEP_W){1'b0}}, r_t_step};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg.quality = r_quality;
    assign o_cfg.t_step  = r_t_step;

endmodule

`default_nettype wire

### hw/rtl/hccp_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module hccp_mul #(
    parameter int MW = 20
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic signed [MW-1:0]   i_a,
    input  wire logic signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0]      o_prod
);

    logic signed [2*MW-1:0] r_prod;

    // The product holds while the enable is low, so a stalled result keeps it.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### hw/rtl/hccp_seq.sv
// Sequencer and datapath: segment set-up and curve point evaluation on the shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module hccp_seq #(
    parameter int MAX_QUALITY = 64,
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  hccp_pkg::t_cfg      i_cfg,
    hccp_in_if.sink             i_pt,
    hccp_out_if.source          o_crv
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = T_FRAC_BITS;
    localparam int TV  = F + 1;
    localparam int MW  = (F + 2 > CW + 4) ? F + 2 : CW + 4;
    localparam int PW  = 2 * MW;
    localparam int EW  = CW + 4;
    localparam int TSW = ((TV > hccp_pkg::T_STEP_W) ? TV : hccp_pkg::T_STEP_W) + 1;
    localparam int QW  = hccp_pkg::QUALITY_W;

    localparam logic [TV-1:0]  T_ONE = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0]  HALF  = {{(PW-1){1'b0}}, 1'b1} << (F - 1);
    localparam logic [QW-1:0]  Q_MAX = QW'(MAX_QUALITY);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_T2,
        ST_CUBE,
        ST_T3,
        ST_AX,
        ST_TY,
        ST_BY,
        ST_AY,
        ST_DONE
    } t_state;

    t_state                 r_state;

    logic signed [CW-1:0]   r_prev_px;
    logic signed [CW-1:0]   r_prev_py;
    logic signed [CW-1:0]   r_prev_hx;
    logic signed [CW-1:0]   r_prev_hy;
    logic                   r_have;

    logic signed [CW-1:0]   r_s0x;
    logic signed [CW-1:0]   r_s0y;
    logic signed [CW:0]     r_t0x;
    logic signed [CW:0]     r_t0y;
    logic signed [CW+2:0]   r_ax;
    logic signed [CW+2:0]   r_ay;
    logic signed [CW+3:0]   r_bx;
    logic signed [CW+3:0]   r_by;

    logic [TV-1:0]          r_t;
    logic [TV-1:0]          r_t2;
    logic [TV-1:0]          r_t3;
    logic [QW-1:0]          r_k;
    logic [QW-1:0]          r_qm1;
    logic signed [PW-1:0]   r_accx;
    logic signed [PW-1:0]   r_accy;

    logic                   r_ovalid;
    logic signed [CW-1:0]   r_ox;
    logic signed [CW-1:0]   r_oy;
    logic                   r_olast;

    logic                   mul_en;
    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [PW-1:0]   prod;

    logic signed [EW-1:0]   e_d;
    logic signed [EW-1:0]   e_t0x;
    logic signed [EW-1:0]   e_t0y;
    logic signed [EW-1:0]   e_t1x;
    logic signed [EW-1:0]   e_t1y;
    logic signed [EW-1:0]   e_dy;
    logic signed [EW-1:0]   e_ax;
    logic signed [EW-1:0]   e_ay;
    logic signed [EW-1:0]   e_bx;
    logic signed [EW-1:0]   e_by;
    logic [QW-1:0]          q_eff;
    logic [PW-1:0]          rnd_prod;
    logic signed [PW-1:0]   n_accy;
    logic [TSW-1:0]         n_tsum;
    logic [TV-1:0]          n_t;
    logic                   out_free;
    logic                   seg_last;

    function automatic logic signed [EW-1:0] ext(input logic signed [CW-1:0] v);
        ext = {{(EW-CW){v[CW-1]}}, v};
    endfunction

    function automatic logic signed [MW-1:0] ext_u(input logic [TV-1:0] v);
        ext_u = $signed({{(MW-TV){1'b0}}, v});
    endfunction

    function automatic logic signed [PW-1:0] acc_init(input logic signed [CW-1:0] v);
        logic signed [PW-1:0] w;
        w = {{(PW-CW){v[CW-1]}}, v};
        acc_init = (w <<< F) + $signed(HALF);
    endfunction

    // The half has already been added, so rounding is a floor shift and a clamp.
    function automatic logic [CW-1:0] round_sat(input logic signed [PW-1:0] v);
        logic [PW-F-1:0]  r;
        logic [PW-F-CW:0] hi_bits;
        r       = v[PW-1:F];
        hi_bits = r[PW-F-1:CW-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            round_sat = r[CW-1:0];
        end else if (r[PW-F-1]) begin
            round_sat = {1'b1, {(CW-1){1'b0}}};
        end else begin
            round_sat = {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    hccp_mul #(.MW(MW)) u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Segment coefficients: C = P0 + t3*A + t2*B + t*T0 per axis.
    always_comb begin
        e_d   = ext(i_pt.point_x) - ext(r_prev_px);
        e_dy  = ext(i_pt.point_y) - ext(r_prev_py);
        e_t0x = ext(r_prev_hx) - ext(r_prev_px);
        e_t0y = ext(r_prev_hy) - ext(r_prev_py);
        e_t1x = ext(i_pt.handle_x) - ext(i_pt.point_x);
        e_t1y = ext(i_pt.handle_y) - ext(i_pt.point_y);
        e_ax  = e_t0x + e_t1x - (e_d <<< 1);
        e_ay  = e_t0y + e_t1y - (e_dy <<< 1);
        e_bx  = (e_d <<< 1) + e_d - (e_t0x <<< 1) - e_t1x;
        e_by  = (e_dy <<< 1) + e_dy - (e_t0y <<< 1) - e_t1y;
    end

    always_comb begin
        priority if (i_cfg.quality == '0) begin
            q_eff = {{(QW-1){1'b0}}, 1'b1};
        end else if (i_cfg.quality > Q_MAX) begin
            q_eff = Q_MAX;
        end else begin
            q_eff = i_cfg.quality;
        end
    end

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            ST_SQ: begin
                mul_a = ext_u(r_t);
                mul_b = ext_u(r_t);
            end
            ST_T2: begin
                mul_a = ext_u(r_t);
                mul_b = MW'(r_t0x);
            end
            ST_CUBE: begin
                mul_a = ext_u(r_t2);
                mul_b = ext_u(r_t);
            end
            ST_T3: begin
                mul_a = ext_u(r_t2);
                mul_b = MW'(r_bx);
            end
            ST_AX: begin
                mul_a = ext_u(r_t3);
                mul_b = MW'(r_ax);
            end
            ST_TY: begin
                mul_a = ext_u(r_t);
                mul_b = MW'(r_t0y);
            end
            ST_BY: begin
                mul_a = ext_u(r_t2);
                mul_b = MW'(r_by);
            end
            ST_AY: begin
                mul_a = ext_u(r_t3);
                mul_b = MW'(r_ay);
            end
            ST_IDLE, ST_DONE: begin
                mul_en = 1'b0;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign rnd_prod = $unsigned(prod) + HALF;
    assign n_accy   = r_accy + prod;
    assign n_tsum   = TSW'(r_t) + TSW'(i_cfg.t_step);
    assign n_t      = (n_tsum > TSW'(T_ONE)) ? T_ONE : n_tsum[TV-1:0];
    assign out_free = !r_ovalid || o_crv.ready;
    assign seg_last = (r_k == r_qm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // In the last step the output register is loaded or held below instead.
            if (o_crv.ready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pt.valid) begin
                        r_prev_px <= i_pt.point_x;
                        r_prev_py <= i_pt.point_y;
                        r_prev_hx <= i_pt.handle_x;
                        r_prev_hy <= i_pt.handle_y;
                        r_have    <= 1'b1;
                        if (!i_pt.start_curve && r_have) begin
                            r_s0x   <= r_prev_px;
                            r_s0y   <= r_prev_py;
                            r_t0x   <= e_t0x[CW:0];
                            r_t0y   <= e_t0y[CW:0];
                            r_ax    <= e_ax[CW+2:0];
                            r_ay    <= e_ay[CW+2:0];
                            r_bx    <= e_bx;
                            r_by    <= e_by;
                            r_t     <= '0;
                            r_k     <= '0;
                            r_qm1   <= q_eff - {{(QW-1){1'b0}}, 1'b1};
                            r_state <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    r_accx  <= acc_init(r_s0x);
                    r_accy  <= acc_init(r_s0y);
                    r_state <= ST_T2;
                end
                ST_T2: begin
                    r_t2    <= rnd_prod[F +: TV];
                    r_state <= ST_CUBE;
                end
                ST_CUBE: begin
                    r_accx  <= r_accx + prod;
                    r_state <= ST_T3;
                end
                ST_T3: begin
                    r_t3    <= rnd_prod[F +: TV];
                    r_state <= ST_AX;
                end
                ST_AX: begin
                    r_accx  <= r_accx + prod;
                    r_state <= ST_TY;
                end
                ST_TY: begin
                    r_accx  <= r_accx + prod;
                    r_state <= ST_BY;
                end
                ST_BY: begin
                    r_accy  <= n_accy;
                    r_state <= ST_AY;
                end
                ST_AY: begin
                    r_accy  <= n_accy;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // Waits here, product held, until the output register is free.
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ox     <= round_sat(r_accx);
                        r_oy     <= round_sat(n_accy);
                        r_olast  <= seg_last;
                        if (seg_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + {{(QW-1){1'b0}}, 1'b1};
                            r_t     <= n_t;
                            r_state <= ST_SQ;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_pt.ready       = (r_state == ST_IDLE);
    assign o_crv.valid      = r_ovalid;
    assign o_crv.curve_x    = r_ox;
    assign o_crv.curve_y    = r_oy;
    assign o_crv.last_point = r_olast;

endmodule

`default_nettype wire

### hw/rtl/hermite_cubic_curve_points.sv
// Top level of the Hermite cubic curve point generator.
//
//  channel   direction  beat                                          handshake
//  i_pt      in         point_x, point_y, handle_x, handle_y, start   valid/ready
//  o_crv     out        curve_x, curve_y, last_point                  valid/ready
//  apb       in/out     quality (0x0), t_step (0x4)                   psel/penable
//
// A control point that opens a curve is taken and starts no evaluation. A point that
// closes a segment holds i_pt.ready low while the shared multiplier evaluates quality
// curve points, each in eight products and the output load. A stalled output beat
// holds the sequencer at its last step; the final beat of a segment sits in the output
// register while the next control point is taken. Reset is synchronous; quality resets
// to 16 and t_step to 4096.
`timescale 1ns / 1ps
`default_nettype none

module hermite_cubic_curve_points #(
    parameter int MAX_QUALITY = 64,
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    hccp_in_if.sink                               i_pt,
    hccp_out_if.source                            o_crv,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [hccp_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [hccp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [hccp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    hccp_pkg::t_cfg cfg;

    hccp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hccp_seq #(
        .MAX_QUALITY (MAX_QUALITY),
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pt    (i_pt),
        .o_crv   (o_crv)
    );

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the Hermite cubic curve point generator.
`timescale 1ns / 1ps

module tb;

    localparam int COORD_W   = 16;
    localparam int T_FRAC    = 16;
    localparam int MAX_QUAL  = 64;
    localparam longint T_ONE  = longint'(1) << T_FRAC;
    localparam longint T_HALF = T_ONE >> 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] hx;
        logic signed [COORD_W-1:0] hy;
        logic                      start;
    } t_ctrl_point;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      is_last;
    } t_curve_point;

    class curve_scoreboard;
        t_curve_point                   pending_points[$];
        logic [hccp_pkg::QUALITY_W-1:0] quality;
        logic [hccp_pkg::T_STEP_W-1:0]  t_step;
        longint                         prev_px, prev_py, prev_hx, prev_hy;
        bit                             have_prev;
        int                             mismatches;

        function new();
            quality    = hccp_pkg::QUALITY_RESET;
            t_step     = hccp_pkg::T_STEP_RESET;
            prev_px    = 0;
            prev_py    = 0;
            prev_hx    = 0;
            prev_hy    = 0;
            have_prev  = 0;
            mismatches = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function logic signed [COORD_W-1:0] sat_coord(input longint acc);
            longint r;
            r = (acc + T_HALF) >>> T_FRAC;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[COORD_W-1:0];
        endfunction

        // Works out the curve points that one accepted control point causes.
        function void note_point(input t_ctrl_point p);
            longint q, t, t2, t3, h0, h1, h2, h3;
            longint px, py, t0x, t0y, t1x, t1y, ax, ay;
            t_curve_point cp;
            px = longint'(p.px);
            py = longint'(p.py);
            if (!p.start && have_prev) begin
                q = longint'(quality);
                if (q == 0) q = 1;
                if (q > MAX_QUAL) q = MAX_QUAL;
                t0x = prev_hx - prev_px;
                t0y = prev_hy - prev_py;
                t1x = longint'(p.hx) - px;
                t1y = longint'(p.hy) - py;
                for (longint k = 0; k < q; k++) begin
                    t = k * longint'(t_step);
                    if (t > T_ONE) t = T_ONE;
                    t2 = (t * t + T_HALF) >>> T_FRAC;
                    t3 = (t2 * t + T_HALF) >>> T_FRAC;
                    h0 = 2 * t3 - 3 * t2 + T_ONE;
                    h1 = -2 * t3 + 3 * t2;
                    h2 = t3 - 2 * t2 + t;
                    h3 = t3 - t2;
                    ax = h0 * prev_px + h1 * px + h2 * t0x + h3 * t1x;
                    ay = h0 * prev_py + h1 * py + h2 * t0y + h3 * t1y;
                    cp.x       = sat_coord(ax);
                    cp.y       = sat_coord(ay);
                    cp.is_last = (k + 1 == q);
                    pending_points.insert(pending_points.size(), cp);
                end
            end
            prev_px   = px;
            prev_py   = py;
            prev_hx   = longint'(p.hx);
            prev_hy   = longint'(p.hy);
            have_prev = 1;
        endfunction

        task check_curve(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                         input logic is_last);
            t_curve_point e;
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected curve point x=%0d y=%0d last=%0b", x, y, is_last));
            end else begin
                e = pending_points.pop_front();
                if (x !== e.x)
                    report($sformatf("curve_x %0d, expected %0d", x, e.x));
                if (y !== e.y)
                    report($sformatf("curve_y %0d, expected %0d", y, e.y));
                if (is_last !== e.is_last)
                    report($sformatf("last_point %0b, expected %0b", is_last, e.is_last));
            end
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [hccp_pkg::APB_ADDR_W-1:0] paddr;
    logic [hccp_pkg::APB_DATA_W-1:0] pwdata;
    logic [hccp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    hccp_in_if  #(.COORD_WIDTH(COORD_W)) pt_if ();
    hccp_out_if #(.COORD_WIDTH(COORD_W)) crv_if ();

    hermite_cubic_curve_points #(
        .MAX_QUALITY(MAX_QUAL),
        .COORD_WIDTH(COORD_W),
        .T_FRAC_BITS(T_FRAC)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if),
        .o_crv  (crv_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    curve_scoreboard sb = new();

    int tx_idle_pct = 21;
    int rx_idle_pct = 21;
    int rx_hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random back-pressure, with an occasional long hold-off on request.
    initial begin
        crv_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles != 0) begin
                crv_if.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            crv_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && crv_if.valid && crv_if.ready)
            sb.check_curve(crv_if.curve_x, crv_if.curve_y, crv_if.last_point);
    end

    function automatic t_ctrl_point mk_point(input int px, input int py, input int hx,
                                             input int hy, input bit start);
        t_ctrl_point p;
        p.px    = px[COORD_W-1:0];
        p.py    = py[COORD_W-1:0];
        p.hx    = hx[COORD_W-1:0];
        p.hy    = hy[COORD_W-1:0];
        p.start = start;
        return p;
    endfunction

    function automatic int rand_coord();
        int v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? 32767 : -32768;
            1, 2, 3: v = int'($signed(16'($urandom)));
            default: v = int'($urandom_range(0, 4000)) - 2000;
        endcase
        return v;
    endfunction

    // Handles mostly sit near their point; now and then anywhere in range.
    function automatic int rand_handle(input int base);
        int v;
        if ($urandom_range(0, 4) == 0)
            v = rand_coord();
        else
            v = base + int'($urandom_range(0, 6000)) - 3000;
        return v;
    endfunction

    function automatic t_ctrl_point rand_point(input bit opens_curve);
        int px, py;
        bit start;
        px = rand_coord();
        py = rand_coord();
        if (opens_curve)
            start = ($urandom_range(0, 99) >= 3);
        else
            start = ($urandom_range(0, 99) < 5);
        return mk_point(px, py, rand_handle(px), rand_handle(py), start);
    endfunction

    task automatic send_point(input t_ctrl_point p);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            pt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        pt_if.valid       <= 1'b1;
        pt_if.point_x     <= p.px;
        pt_if.point_y     <= p.py;
        pt_if.handle_x    <= p.hx;
        pt_if.handle_y    <= p.hy;
        pt_if.start_curve <= p.start;
        do @(posedge i_clk); while (!pt_if.ready);
        sb.note_point(p);
    endtask

    task automatic send_random(input int n);
        int left;
        int len;
        left = n;
        while (left > 0) begin
            len = $urandom_range(2, 7);
            for (int i = 0; i < len && left > 0; i++) begin
                send_point(rand_point(i == 0));
                left--;
            end
        end
    endtask

    // Sender stops and waits for every outstanding curve point to come out.
    task automatic wait_drained();
        pt_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_points.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [hccp_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] q_word, input logic [31:0] step_word);
        apb_write({hccp_pkg::REG_QUALITY, 2'b00}, q_word);
        sb.quality = q_word[hccp_pkg::QUALITY_W-1:0];
        apb_write({hccp_pkg::REG_T_STEP, 2'b00}, step_word);
        sb.t_step = step_word[hccp_pkg::T_STEP_W-1:0];
    endtask

    initial begin
        int q;
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        pt_if.valid       <= 1'b0;
        pt_if.point_x     <= '0;
        pt_if.point_y     <= '0;
        pt_if.handle_x    <= '0;
        pt_if.handle_y    <= '0;
        pt_if.start_curve <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings. The very first point continues no curve, so it must stay silent.
        send_point(mk_point(32767, -32768, -32768, 32767, 0));
        send_point(mk_point(-32768, 32767, 32767, -32768, 0));
        send_point(mk_point(100, 200, 300, 400, 1));
        send_point(mk_point(1000, -1000, 1500, -500, 0));
        send_point(mk_point(0, 0, 0, 0, 0));
        send_point(mk_point(-1, -1, -1, -1, 0));
        send_point(mk_point(32767, 32767, 32767, 32767, 0));
        send_point(mk_point(-32768, -32768, -32768, -32768, 0));
        send_point(mk_point(5, 5, 5, 5, 1));
        send_point(mk_point(-5, -5, -5, -5, 1));
        send_point(mk_point(20000, -20000, -20000, 20000, 0));
        send_point(mk_point(-20000, 20000, 20000, -20000, 0));
        send_random(20);
        wait_drained();

        // A long stretch with no idling on either side.
        set_config(32'd4, 32'd16384);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(30);
        tx_idle_pct = 21;
        rx_idle_pct = 21;
        // The receiver holds off while points keep coming, so the input backs up.
        rx_hold_cycles = 400;
        send_random(20);
        wait_drained();

        set_config(32'd1, 32'd65536);
        send_random(25);
        wait_drained();

        set_config(32'd64, 32'd1024);
        send_random(8);
        wait_drained();

        // Quality above the maximum, and t running past one.
        set_config(32'd127, 32'd2000);
        send_random(6);
        wait_drained();

        // Quality zero and a zero step.
        set_config(32'd0, 32'd0);
        send_random(15);
        wait_drained();

        set_config(32'd8, 32'd131071);
        send_random(15);
        wait_drained();

        // Upper bits of the written word fall outside the quality field.
        set_config(32'hFFFF_FF03, 32'd1);
        send_random(15);
        wait_drained();

        repeat (4) begin
            q = $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0)
                set_config(q, $urandom_range(0, 131071));
            else
                set_config(q, 65536 / q);
            send_random(11);
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
hw/rtl/hccp_pkg.sv
hw/rtl/hccp_if.sv
hw/rtl/hccp_cfg.sv
hw/rtl/hccp_mul.sv
hw/rtl/hccp_seq.sv
hw/rtl/hermite_cubic_curve_points.sv
test/tb.sv
